FILE: rtl/pjde_pkg.sv
// Shared types, constants and saturation helpers for the pose joint distance error unit.
package pjde_pkg;

  localparam int unsigned SumW       = 48;
  localparam int unsigned DivNumW    = 64;
  localparam int unsigned DivDenW    = 33;
  localparam int unsigned QueueDepth = 2;

  localparam logic signed [31:0] S32Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;

  // Reset values of the focal lengths and cube extents (1.0 in Q16.16).
  localparam logic signed [31:0] FocalReset = 32'sh0001_0000;
  localparam logic [30:0]        CubeReset  = 31'h0001_0000;

  typedef enum logic [2:0] {
    CFG_FOCAL_X     = 3'd0,
    CFG_FOCAL_Y     = 3'd1,
    CFG_PRINCIPAL_X = 3'd2,
    CFG_PRINCIPAL_Y = 3'd3,
    CFG_CUBE_X      = 3'd4,
    CFG_CUBE_Y      = 3'd5,
    CFG_CUBE_Z      = 3'd6,
    CFG_USE_WEIGHT  = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_IMG_M1,
    ST_IMG_M2,
    ST_IMG_DS,
    ST_IMG_DW,
    ST_Z_M1,
    ST_Z_ADD,
    ST_CAM_M,
    ST_CAM_DS,
    ST_CAM_DW,
    ST_SIDE_END,
    ST_SQ0,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_RT_S,
    ST_RT_W,
    ST_FINISH,
    ST_MEAN_DS,
    ST_MEAN_DW,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic signed [31:0] focal_x;
    logic signed [31:0] focal_y;
    logic signed [31:0] principal_x;
    logic signed [31:0] principal_y;
    logic [30:0]        cube_x;
    logic [30:0]        cube_y;
    logic [30:0]        cube_z;
    logic               use_weight;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] pred_x;
    logic signed [31:0] pred_y;
    logic signed [31:0] pred_z;
    logic signed [31:0] label_x;
    logic signed [31:0] label_y;
    logic signed [31:0] label_z;
    logic signed [31:0] center_u;
    logic signed [31:0] center_v;
    logic [30:0]        center_depth;
    logic               counts;
    logic               last;
  } item_t;

  typedef struct packed {
    logic                       start;
    logic signed [DivNumW-1:0]  num;
    logic signed [DivDenW-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  // Clamp a wide two's complement value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (&v[65:31] || ~|v[65:31]) begin
      r = v[31:0];
    end else if (v[65]) begin
      r = S32Min;
    end else begin
      r = S32Max;
    end
    return r;
  endfunction

endpackage

FILE: rtl/pjde_div.sv
// Shared sequential signed divider with truncation and 32-bit saturation.
module pjde_div import pjde_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned Steps = 33;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic          busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [33:0]   rem_q;
  logic [32:0]   quo_q, lo_q, dmag_q;
  logic          neg_q;
  logic signed [31:0] res_q;

  logic [63:0] nmag;
  logic [32:0] dmag;
  logic [33:0] trial, rem_next;
  logic        take;
  logic [32:0] quo_next;

  function automatic logic signed [31:0] finalize(input logic [32:0] q, input logic neg);
    logic [32:0] nq;
    logic signed [31:0] r;
    nq = ~q + 33'd1;
    if (neg) begin
      r = (q > 33'h0_8000_0000) ? S32Min : nq[31:0];
    end else begin
      r = (q > 33'h0_7fff_ffff) ? S32Max : q[31:0];
    end
    return r;
  endfunction

  assign nmag     = req_i.num[63] ? (~req_i.num + 64'd1) : req_i.num;
  assign dmag     = req_i.den[32] ? (~req_i.den + 33'd1) : req_i.den;
  assign trial    = {rem_q[32:0], lo_q[32]};
  assign take     = trial >= {1'b0, dmag_q};
  assign rem_next = take ? (trial - {1'b0, dmag_q}) : trial;
  assign quo_next = {quo_q[31:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.den == '0 || 33'(nmag[63:33]) >= dmag) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CntW'(Steps);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q  <= req_i.num[63] ^ req_i.den[32];
      rem_q  <= 34'(nmag[63:33]);
      lo_q   <= nmag[32:0];
      quo_q  <= '0;
      dmag_q <= dmag;
      if (req_i.den == '0) begin
        if (req_i.num == '0) begin
          res_q <= '0;
        end else begin
          res_q <= req_i.num[63] ? S32Min : S32Max;
        end
      end else begin
        res_q <= (req_i.num[63] ^ req_i.den[32]) ? S32Min : S32Max;
      end
    end else if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
      lo_q  <= {lo_q[31:0], 1'b0};
      if (cnt_q == CntW'(1)) begin
        res_q <= finalize(quo_next, neg_q);
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = res_q;

endmodule

FILE: rtl/pjde_sqrt.sv
// Sequential integer square root, two radicand bits per cycle.
module pjde_sqrt import pjde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);

  localparam int unsigned Steps = 32;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [63:0]     rad_q;
  logic [33:0]     rem_q;
  logic [31:0]     root_q;

  logic [35:0] t, trial, rem_next;
  logic        take;
  logic [31:0] root_next;

  assign t         = {rem_q, rad_q[63:62]};
  assign trial     = 36'({root_q, 2'b01});
  assign take      = t >= trial;
  assign rem_next  = take ? (t - trial) : t;
  assign root_next = {root_q[30:0], take};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Steps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= req_i.rad;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= rem_next[33:0];
      root_q <= root_next;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

FILE: rtl/pjde_front.sv
// Front end: takes joint requests and marks whether each joint counts towards the mean.
module pjde_front import pjde_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic signed [31:0] pred_x_i,
  input  logic signed [31:0] pred_y_i,
  input  logic signed [31:0] pred_z_i,
  input  logic signed [31:0] label_x_i,
  input  logic signed [31:0] label_y_i,
  input  logic signed [31:0] label_z_i,
  input  logic signed [31:0] center_u_i,
  input  logic signed [31:0] center_v_i,
  input  logic [30:0]        center_depth_i,
  input  logic signed [31:0] joint_weight_i,
  input  logic               last_joint_i,
  input  logic               use_weight_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               push_valid_o,
  output item_t              push_item_o,
  input  logic               push_ready_i
);

  localparam logic [32:0] OneFix33 = 33'(1) << FRAC_BITS;
  localparam logic [42:0] OneFix43 = 43'(1) << FRAC_BITS;

  logic [32:0] diff, mag;
  logic [42:0] scaled;

  // A weight counts as one when |w - 1| * 1000 stays below one.
  assign diff   = 33'(joint_weight_i) - OneFix33;
  assign mag    = diff[32] ? (~diff + 33'd1) : diff;
  assign scaled = 43'(mag) * 43'd1000;

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

  always_comb begin
    push_item_o              = '0;
    push_item_o.pred_x       = pred_x_i;
    push_item_o.pred_y       = pred_y_i;
    push_item_o.pred_z       = pred_z_i;
    push_item_o.label_x      = label_x_i;
    push_item_o.label_y      = label_y_i;
    push_item_o.label_z      = label_z_i;
    push_item_o.center_u     = center_u_i;
    push_item_o.center_v     = center_v_i;
    push_item_o.center_depth = center_depth_i;
    push_item_o.counts       = !use_weight_i || (scaled < OneFix43);
    push_item_o.last         = last_joint_i;
  end

endmodule

FILE: rtl/pjde_queue.sv
// Short request queue between the front end and the back end.
module pjde_queue import pjde_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t           entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   fill_q;
  logic            push, pop;

  assign push_ready_o = fill_q != (PtrW + 1)'(QueueDepth);
  assign pop_valid_o  = fill_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/pjde_back.sv
// Back end: sequences projection, distance, accumulation and the batch mean for one joint.
module pjde_back import pjde_pkg::*; #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  item_t              q_item_i,
  output div_req_t           div_req_o,
  input  div_rsp_t           div_rsp_i,
  output sqrt_req_t          sqrt_req_o,
  input  sqrt_rsp_t          sqrt_rsp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] proj_u_o,
  output logic signed [31:0] proj_v_o,
  output logic signed [31:0] proj_depth_o,
  output logic [30:0]        mean_error_o,
  output logic               error_ready_o,
  output logic               none_counted_o
);

  back_state_e state_q, state_d;
  logic        side_q, axis_q;
  logic [SumW-1:0]       sum_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic        out_valid_q;

  item_t              it_q;
  logic signed [65:0] p_q;
  logic signed [32:0] ma, mb;
  logic [63:0]        sq_q;
  logic signed [31:0] cur_u_q, cur_v_q, cur_d_q, cam_x_q, cam_y_q;
  logic signed [31:0] pu_q, pv_q, pd_q, pcx_q, pcy_q;
  logic [30:0]        mean_q;

  logic signed [31:0] n_sel, nz_sel, focal_sel, c_sel, pp_sel, img_sel;
  logic [30:0]        cube_sel;
  logic [31:0]        fabs_sel;
  logic signed [31:0] a_sat, usum, du, dx, dy, dd;
  logic [SumW:0]      sum_ext;
  logic               load;

  // Operand selection for the current side (predicted or label) and axis.
  assign n_sel     = side_q ? (axis_q ? it_q.label_y : it_q.label_x)
                            : (axis_q ? it_q.pred_y  : it_q.pred_x);
  assign nz_sel    = side_q ? it_q.label_z : it_q.pred_z;
  assign cube_sel  = axis_q ? cfg_i.cube_y : cfg_i.cube_x;
  assign focal_sel = axis_q ? cfg_i.focal_y : cfg_i.focal_x;
  assign fabs_sel  = focal_sel[31] ? (~focal_sel + 32'd1) : focal_sel;
  assign c_sel     = axis_q ? it_q.center_v : it_q.center_u;
  assign pp_sel    = axis_q ? cfg_i.principal_y : cfg_i.principal_x;
  assign img_sel   = axis_q ? cur_v_q : cur_u_q;

  assign a_sat = sat32(p_q >>> FRAC_BITS);
  assign usum  = sat32(66'(div_rsp_i.quot) + 66'(c_sel));
  assign du    = sat32(66'(img_sel) - 66'(pp_sel));
  assign dx    = sat32(66'(pcx_q) - 66'(cam_x_q));
  assign dy    = sat32(66'(pcy_q) - 66'(cam_y_q));
  assign dd    = sat32(66'(pd_q) - 66'(cur_d_q));

  assign sum_ext = {1'b0, sum_q} + (SumW + 1)'(sqrt_rsp_i.root);
  assign load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (q_valid_i) state_d = ST_IMG_M1;
      ST_IMG_M1:   state_d = ST_IMG_M2;
      ST_IMG_M2:   state_d = ST_IMG_DS;
      ST_IMG_DS:   state_d = ST_IMG_DW;
      ST_IMG_DW:   if (div_rsp_i.done) state_d = axis_q ? ST_Z_M1 : ST_IMG_M1;
      ST_Z_M1:     state_d = ST_Z_ADD;
      ST_Z_ADD:    state_d = ST_CAM_M;
      ST_CAM_M:    state_d = ST_CAM_DS;
      ST_CAM_DS:   state_d = ST_CAM_DW;
      ST_CAM_DW:   if (div_rsp_i.done) state_d = axis_q ? ST_SIDE_END : ST_CAM_M;
      ST_SIDE_END: begin
        if (!side_q) begin
          state_d = ST_IMG_M1;
        end else begin
          state_d = it_q.counts ? ST_SQ0 : ST_FINISH;
        end
      end
      ST_SQ0:      state_d = ST_SQ1;
      ST_SQ1:      state_d = ST_SQ2;
      ST_SQ2:      state_d = ST_SQ3;
      ST_SQ3:      state_d = ST_RT_S;
      ST_RT_S:     state_d = ST_RT_W;
      ST_RT_W:     if (sqrt_rsp_i.done) state_d = ST_FINISH;
      ST_FINISH:   state_d = (it_q.last && cnt_q != '0) ? ST_MEAN_DS : ST_OUT;
      ST_MEAN_DS:  state_d = ST_MEAN_DW;
      ST_MEAN_DW:  if (div_rsp_i.done) state_d = ST_OUT;
      ST_OUT:      if (load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Unit requests and multiplier operands per state.
  always_comb begin
    q_ready_o  = 1'b0;
    ma         = '0;
    mb         = '0;
    div_req_o  = '0;
    sqrt_req_o = '0;
    case (state_q)
      ST_IDLE: q_ready_o = 1'b1;
      ST_IMG_M1: begin
        ma = 33'(n_sel);
        mb = 33'(cube_sel);
      end
      ST_IMG_M2: begin
        ma = 33'(a_sat);
        mb = 33'(fabs_sel);
      end
      ST_IMG_DS: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = DivNumW'(a_sat) <<< FRAC_BITS;
        div_req_o.den   = DivDenW'(it_q.center_depth);
      end
      ST_Z_M1: begin
        ma = 33'(nz_sel);
        mb = 33'(cfg_i.cube_z);
      end
      ST_CAM_M: begin
        ma = 33'(du);
        mb = 33'(cur_d_q);
      end
      ST_CAM_DS: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = p_q[63:0];
        div_req_o.den   = DivDenW'(focal_sel);
      end
      ST_SQ0: begin
        ma = 33'(dx);
        mb = 33'(dx);
      end
      ST_SQ1: begin
        ma = 33'(dy);
        mb = 33'(dy);
      end
      ST_SQ2: begin
        ma = 33'(dd);
        mb = 33'(dd);
      end
      ST_RT_S: begin
        sqrt_req_o.start = 1'b1;
        sqrt_req_o.rad   = sq_q;
      end
      ST_MEAN_DS: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = DivNumW'(sum_q);
        div_req_o.den   = DivDenW'(cnt_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      side_q      <= 1'b0;
      axis_q      <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          side_q <= 1'b0;
          axis_q <= 1'b0;
        end
        ST_IMG_DW, ST_CAM_DW: if (div_rsp_i.done) axis_q <= ~axis_q;
        ST_SIDE_END: side_q <= 1'b1;
        ST_RT_W: begin
          if (sqrt_rsp_i.done) begin
            sum_q <= sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
            if (cnt_q != '1) begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (load && it_q.last) begin
            sum_q <= '0;
            cnt_q <= '0;
          end
        end
        default: ;
      endcase
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= ma * mb;
    case (state_q)
      ST_IDLE: if (q_valid_i) it_q <= q_item_i;
      ST_IMG_DW: begin
        if (div_rsp_i.done) begin
          if (axis_q) cur_v_q <= usum;
          else        cur_u_q <= usum;
        end
      end
      ST_Z_ADD: cur_d_q <= sat32(66'(a_sat) + 66'(it_q.center_depth));
      ST_CAM_DW: begin
        if (div_rsp_i.done) begin
          if (axis_q) cam_y_q <= div_rsp_i.quot;
          else        cam_x_q <= div_rsp_i.quot;
        end
      end
      ST_SIDE_END: begin
        if (!side_q) begin
          pu_q  <= cur_u_q;
          pv_q  <= cur_v_q;
          pd_q  <= cur_d_q;
          pcx_q <= cam_x_q;
          pcy_q <= cam_y_q;
        end
      end
      ST_SQ0:    sq_q <= '0;
      ST_SQ1, ST_SQ2, ST_SQ3: sq_q <= sq_q + p_q[63:0];
      ST_FINISH: mean_q <= '0;
      ST_MEAN_DW: if (div_rsp_i.done) mean_q <= div_rsp_i.quot[30:0];
      ST_OUT: begin
        if (load) begin
          proj_u_o       <= pu_q;
          proj_v_o       <= pv_q;
          proj_depth_o   <= pd_q;
          mean_error_o   <= mean_q;
          error_ready_o  <= it_q.last;
          none_counted_o <= it_q.last && (cnt_q == '0);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/pose_joint_distance_error_unit.sv
// Top level of the pose joint distance error unit.
// Each request is one joint: a normalised predicted and label point, the crop centre and a
// weight. Both points are scaled into image space and back-projected through a pinhole camera;
// the distance between them is added to a saturating batch sum when the joint counts. Every
// joint returns the predicted image point, and the joint marked last also returns the batch
// mean (or raises none_counted) and clears the sums. The back end's time per joint is set by
// the shared divider, which produces one quotient bit per cycle and is used eight times per
// joint (nine on a last joint whose batch has a counted joint), and by the 32-step square
// root. The front end keeps taking requests into a two-entry queue while the back end works,
// until the queue is full, and a finished result waits in its output register while the next
// joint is worked on; that joint leaves the back end only once the waiting result is taken.
module pose_joint_distance_error_unit import pjde_pkg::*; #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pred_x_i,
  input  logic signed [31:0] pred_y_i,
  input  logic signed [31:0] pred_z_i,
  input  logic signed [31:0] label_x_i,
  input  logic signed [31:0] label_y_i,
  input  logic signed [31:0] label_z_i,
  input  logic signed [31:0] center_u_i,
  input  logic signed [31:0] center_v_i,
  input  logic [30:0]        center_depth_i,
  input  logic signed [31:0] joint_weight_i,
  input  logic               last_joint_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] proj_u_o,
  output logic signed [31:0] proj_v_o,
  output logic signed [31:0] proj_depth_o,
  output logic [30:0]        mean_error_o,
  output logic               error_ready_o,
  output logic               none_counted_o
);

  cfg_t      cfg_q;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  item_t     push_item, pop_item;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  // The configuration registers accept a write in every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal_x     <= FocalReset;
      cfg_q.focal_y     <= FocalReset;
      cfg_q.principal_x <= '0;
      cfg_q.principal_y <= '0;
      cfg_q.cube_x      <= CubeReset;
      cfg_q.cube_y      <= CubeReset;
      cfg_q.cube_z      <= CubeReset;
      cfg_q.use_weight  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FOCAL_X:     cfg_q.focal_x     <= cfg_data_i;
        CFG_FOCAL_Y:     cfg_q.focal_y     <= cfg_data_i;
        CFG_PRINCIPAL_X: cfg_q.principal_x <= cfg_data_i;
        CFG_PRINCIPAL_Y: cfg_q.principal_y <= cfg_data_i;
        CFG_CUBE_X:      cfg_q.cube_x      <= cfg_data_i[30:0];
        CFG_CUBE_Y:      cfg_q.cube_y      <= cfg_data_i[30:0];
        CFG_CUBE_Z:      cfg_q.cube_z      <= cfg_data_i[30:0];
        CFG_USE_WEIGHT:  cfg_q.use_weight  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The front end decides whether the joint counts while the request is taken, so the
  // back end only needs the decision bit.
  pjde_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .pred_x_i       (pred_x_i),
    .pred_y_i       (pred_y_i),
    .pred_z_i       (pred_z_i),
    .label_x_i      (label_x_i),
    .label_y_i      (label_y_i),
    .label_z_i      (label_z_i),
    .center_u_i     (center_u_i),
    .center_v_i     (center_v_i),
    .center_depth_i (center_depth_i),
    .joint_weight_i (joint_weight_i),
    .last_joint_i   (last_joint_i),
    .use_weight_i   (cfg_q.use_weight),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .push_valid_o   (push_valid),
    .push_item_o    (push_item),
    .push_ready_i   (push_ready)
  );

  pjde_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // One divider and one square root unit serve every division and root step of the back end.
  pjde_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pjde_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  pjde_back #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (pop_valid),
    .q_ready_o      (pop_ready),
    .q_item_i       (pop_item),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp),
    .sqrt_req_o     (sqrt_req),
    .sqrt_rsp_i     (sqrt_rsp),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .proj_u_o       (proj_u_o),
    .proj_v_o       (proj_v_o),
    .proj_depth_o   (proj_depth_o),
    .mean_error_o   (mean_error_o),
    .error_ready_o  (error_ready_o),
    .none_counted_o (none_counted_o)
  );

endmodule

FILE: tb/sv/pose_joint_distance_error_unit_tb.sv
// Self-checking testbench for the pose joint distance error unit.
module pose_joint_distance_error_unit_tb;
  import pjde_pkg::*;

  localparam int unsigned Frac      = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned NumRandom = 1250;
  // No request may take longer than this many idle cycles to be accepted somewhere.
  localparam int unsigned StallLimit = 20000;

  localparam longint S32Hi  = 64'sd2147483647;
  localparam longint S32Lo  = -64'sd2147483648;
  localparam longint SumTop = (64'sd1 <<< 48) - 1;
  localparam longint CntTop = (64'sd1 <<< CountW) - 1;

  // One joint request as it is driven onto the ports.
  typedef struct packed {
    logic signed [31:0] pred_x;
    logic signed [31:0] pred_y;
    logic signed [31:0] pred_z;
    logic signed [31:0] label_x;
    logic signed [31:0] label_y;
    logic signed [31:0] label_z;
    logic signed [31:0] center_u;
    logic signed [31:0] center_v;
    logic [30:0]        center_depth;
    logic signed [31:0] joint_weight;
    logic               last_joint;
  } joint_req_t;

  // The result that one joint should produce.
  typedef struct packed {
    logic signed [31:0] proj_u;
    logic signed [31:0] proj_v;
    logic signed [31:0] proj_depth;
    logic [30:0]        mean_error;
    logic               error_ready;
    logic               none_counted;
  } joint_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] pred_x_i = '0;
  logic signed [31:0] pred_y_i = '0;
  logic signed [31:0] pred_z_i = '0;
  logic signed [31:0] label_x_i = '0;
  logic signed [31:0] label_y_i = '0;
  logic signed [31:0] label_z_i = '0;
  logic signed [31:0] center_u_i = '0;
  logic signed [31:0] center_v_i = '0;
  logic [30:0]        center_depth_i = 31'd1;
  logic signed [31:0] joint_weight_i = '0;
  logic               last_joint_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] proj_u_o;
  logic signed [31:0] proj_v_o;
  logic signed [31:0] proj_depth_o;
  logic [30:0]        mean_error_o;
  logic               error_ready_o;
  logic               none_counted_o;

  pose_joint_distance_error_unit #(
    .FRAC_BITS (Frac),
    .COUNT_BITS(CountW)
  ) dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .pred_x_i, .pred_y_i, .pred_z_i, .label_x_i, .label_y_i, .label_z_i,
    .center_u_i, .center_v_i, .center_depth_i, .joint_weight_i, .last_joint_i,
    .out_valid_o, .out_ready_i,
    .proj_u_o, .proj_v_o, .proj_depth_o, .mean_error_o, .error_ready_o, .none_counted_o
  );

  always #6 clk_i = ~clk_i;

  // Camera and crop settings as the predictor sees them, plus the batch accumulators.
  longint cam_focal_x, cam_focal_y, cam_prin_x, cam_prin_y;
  longint crop_x, crop_y, crop_z;
  bit     weighted_only;
  longint batch_sum, batch_count;

  joint_req_t pending_joints[$];
  joint_res_t expected_results[$];

  int     mismatches = 0;
  int     joints_sent = 0;
  int     results_seen = 0;
  int     batches_closed = 0;
  int     empty_batches = 0;
  int     idle_cycles = 0;
  bit     quiet_tail = 1'b0;   // No idling once the run is in its closing stretch.
  bit     hold_request = 1'b0;
  bit     hold_done = 1'b0;
  bit     hold_receiver = 1'b0;
  int     hold_left = 0;
  int     sender_gap = 0;
  int     receiver_gap = 0;

  // ---------------------------------------------------------------------------------------
  // Predictor. Arithmetic is done on 64-bit values, signed but for the unsigned sum of squares;
  // products stay well inside that range since every operand is clamped to 32 bits first.
  // ---------------------------------------------------------------------------------------
  function automatic longint clamp32(longint v);
    if (v > S32Hi) return S32Hi;
    if (v < S32Lo) return S32Lo;
    return v;
  endfunction

  // Arithmetic shift is a floor division by 2^Frac.
  function automatic longint floor_q(longint v);
    return v >>> Frac;
  endfunction

  // Division truncating towards zero; a zero divisor saturates with the numerator's sign.
  function automatic longint quot_clamped(longint num, longint den);
    if (den == 0) begin
      if (num > 0) return S32Hi;
      if (num < 0) return S32Lo;
      return 0;
    end
    return clamp32(num / den);
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // Scales one normalised lateral coordinate into the image.
  function automatic longint lateral_to_image(longint n, longint cube, longint focal,
                                              longint depth, longint centre);
    longint a, b;
    a = clamp32(floor_q(n * cube));
    b = clamp32(floor_q(a * magnitude(focal)));
    return clamp32(quot_clamped(b <<< Frac, depth) + centre);
  endfunction

  // Image point and camera point of one normalised triple.
  task automatic place_point(input longint nx, input longint ny, input longint nz,
                             input joint_req_t r, output longint img[3],
                             output longint camp[3]);
    longint dep;
    dep = longint'(r.center_depth);
    img[0] = lateral_to_image(nx, crop_x, cam_focal_x, dep, longint'(r.center_u));
    img[1] = lateral_to_image(ny, crop_y, cam_focal_y, dep, longint'(r.center_v));
    img[2] = clamp32(clamp32(floor_q(nz * crop_z)) + dep);
    camp[0] = quot_clamped(clamp32(img[0] - cam_prin_x) * img[2], cam_focal_x);
    camp[1] = quot_clamped(clamp32(img[1] - cam_prin_y) * img[2], cam_focal_y);
    camp[2] = img[2];
  endtask

  // Works out the result of one joint and advances the batch accumulators.
  task automatic predict_joint(input joint_req_t r);
    longint pi[3], pc[3], li[3], lc[3];
    longint unsigned sq, m;
    longint d, root_len, mean;
    bit     counts;
    joint_res_t e;
    place_point(r.pred_x, r.pred_y, r.pred_z, r, pi, pc);
    place_point(r.label_x, r.label_y, r.label_z, r, li, lc);
    counts = !weighted_only ||
             (magnitude(longint'(r.joint_weight) - (64'sd1 <<< Frac)) * 1000 <
              (64'sd1 <<< Frac));
    if (counts) begin
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        d = clamp32(pc[i] - lc[i]);
        m = longint'(magnitude(d));
        sq += m * m;
      end
      root_len = int_root(sq);
      batch_sum = (batch_sum + root_len > SumTop) ? SumTop : batch_sum + root_len;
      if (batch_count < CntTop) batch_count++;
    end
    e = '0;
    e.proj_u = pi[0][31:0];
    e.proj_v = pi[1][31:0];
    e.proj_depth = pi[2][31:0];
    if (r.last_joint) begin
      e.error_ready = 1'b1;
      if (batch_count == 0) begin
        e.none_counted = 1'b1;
      end else begin
        mean = batch_sum / batch_count;
        e.mean_error = (mean > S32Hi) ? 31'h7fff_ffff : mean[30:0];
      end
      batch_sum = 0;
      batch_count = 0;
    end
    expected_results = {expected_results, e};
  endtask

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("MISMATCH result %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  // ---------------------------------------------------------------------------------------
  // Driver: offers the queued joints one after another, with random gaps between requests.
  // Valid is raised only when the queue holds a joint and stays up until it is taken.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sender_gap <= 0;
    end else begin
      automatic bit fire = in_valid_i && in_ready_o;
      if (fire) begin
        predict_joint(pending_joints.pop_front());
        joints_sent <= joints_sent + 1;
      end
      if (in_valid_i && !fire) begin
        // Holding the current request.
      end else if (sender_gap > 0) begin
        in_valid_i <= 1'b0;
        sender_gap <= sender_gap - 1;
      end else if (pending_joints.size() > 0) begin
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          in_valid_i <= 1'b0;
          sender_gap <= $urandom_range(1, 8) - 1;
        end else begin
          automatic joint_req_t r = pending_joints[0];
          in_valid_i     <= 1'b1;
          pred_x_i       <= r.pred_x;
          pred_y_i       <= r.pred_y;
          pred_z_i       <= r.pred_z;
          label_x_i      <= r.label_x;
          label_y_i      <= r.label_y;
          label_z_i      <= r.label_z;
          center_u_i     <= r.center_u;
          center_v_i     <= r.center_v;
          center_depth_i <= r.center_depth;
          joint_weight_i <= r.joint_weight;
          last_joint_i   <= r.last_joint;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: compares each accepted result with the oldest expectation and drives the
  // receiver's ready, stalling in random bursts or in one long hold when asked.
  // ---------------------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      receiver_gap <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          automatic joint_res_t e = expected_results.pop_front();
          if (proj_u_o !== e.proj_u)
            report_mismatch("proj_u", proj_u_o, e.proj_u);
          if (proj_v_o !== e.proj_v)
            report_mismatch("proj_v", proj_v_o, e.proj_v);
          if (proj_depth_o !== e.proj_depth)
            report_mismatch("proj_depth", proj_depth_o, e.proj_depth);
          if (mean_error_o !== e.mean_error)
            report_mismatch("mean_error", mean_error_o, e.mean_error);
          if (error_ready_o !== e.error_ready)
            report_mismatch("error_ready", error_ready_o, e.error_ready);
          if (none_counted_o !== e.none_counted)
            report_mismatch("none_counted", none_counted_o, e.none_counted);
          if (e.error_ready) batches_closed <= batches_closed + 1;
          if (e.none_counted) empty_batches <= empty_batches + 1;
        end
      end
      if (hold_receiver) begin
        out_ready_i <= 1'b0;
      end else if (receiver_gap > 0) begin
        out_ready_i <= 1'b0;
        receiver_gap <= receiver_gap - 1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        receiver_gap <= $urandom_range(1, 8) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Long hold on the receiver, counted here in cycles, while the sender keeps offering.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) hold_receiver <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_receiver <= 1'b1;
      hold_left     <= 3000;
      hold_done     <= 1'b1;
    end
  end

  // Watchdog: counts cycles in which no channel accepts anything, outside the long receiver hold.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || hold_receiver) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Watchdog: no request accepted for %0d cycles", StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------------
  function automatic logic signed [31:0] any32();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sh0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0001_ffff;
    endcase
  endfunction

  function automatic logic [30:0] any_depth();
    case ($urandom_range(0, 7))
      0: return 31'h7fff_ffff;
      1: return 31'd1;
      2: return 31'($urandom);
      default: return 31'($urandom_range(32'h0000_8000, 32'h0080_0000));
    endcase
  endfunction

  function automatic logic signed [31:0] any_weight();
    case ($urandom_range(0, 5))
      0: return 32'sh0001_0000;
      1: return 32'sh0001_0000 + $signed($urandom_range(0, 130)) - 32'sd65;
      2: return 32'sh0001_0000 + $signed($urandom_range(0, 300)) - 32'sd150;
      default: return $urandom;
    endcase
  endfunction

  function automatic joint_req_t random_joint(input bit last);
    joint_req_t r;
    r.pred_x = any32();  r.pred_y = any32();  r.pred_z = any32();
    r.label_x = any32(); r.label_y = any32(); r.label_z = any32();
    r.center_u = any32(); r.center_v = any32();
    r.center_depth = any_depth();
    r.joint_weight = any_weight();
    r.last_joint = last;
    return r;
  endfunction

  task automatic push_joint(input joint_req_t r);
    pending_joints = {pending_joints, r};
  endtask

  // Waits until every queued joint has been taken and every result has come back, then
  // lets the clock run on before it returns.
  task automatic drain();
    while (pending_joints.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // Writes one register and updates the predictor's copy of it.
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FOCAL_X:     cam_focal_x = longint'($signed(value));
      CFG_FOCAL_Y:     cam_focal_y = longint'($signed(value));
      CFG_PRINCIPAL_X: cam_prin_x = longint'($signed(value));
      CFG_PRINCIPAL_Y: cam_prin_y = longint'($signed(value));
      CFG_CUBE_X:      crop_x = longint'(value[30:0]);
      CFG_CUBE_Y:      crop_y = longint'(value[30:0]);
      CFG_CUBE_Z:      crop_z = longint'(value[30:0]);
      CFG_USE_WEIGHT:  weighted_only = value[0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] fx, input logic [31:0] fy,
                           input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] cx, input logic [31:0] cy,
                           input logic [31:0] cz, input bit uw);
    write_reg(CFG_FOCAL_X, fx);
    write_reg(CFG_FOCAL_Y, fy);
    write_reg(CFG_PRINCIPAL_X, px);
    write_reg(CFG_PRINCIPAL_Y, py);
    write_reg(CFG_CUBE_X, cx);
    write_reg(CFG_CUBE_Y, cy);
    write_reg(CFG_CUBE_Z, cz);
    write_reg(CFG_USE_WEIGHT, {31'd0, uw});
  endtask

  // A batch of well-formed joints: a few ordinary ones and then the closing joint.
  task automatic queue_batch(input int joints);
    for (int j = 0; j < joints; j++)
      push_joint(random_joint(j == joints - 1));
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------------------
  initial begin
    joint_req_t r;
    int phase_items;
    cam_focal_x = longint'(FocalReset);
    cam_focal_y = longint'(FocalReset);
    cam_prin_x = 0;
    cam_prin_y = 0;
    crop_x = longint'(CubeReset);
    crop_y = longint'(CubeReset);
    crop_z = longint'(CubeReset);
    weighted_only = 1'b0;
    batch_sum = 0;
    batch_count = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed joints under the reset settings: zero points, field extremes, a zero depth.
    r = '0;
    r.center_depth = 31'd1;
    push_joint(r);
    r.pred_x = 32'sh7fff_ffff; r.pred_y = 32'sh8000_0000; r.pred_z = 32'sh7fff_ffff;
    r.label_x = 32'sh8000_0000; r.label_y = 32'sh7fff_ffff; r.label_z = 32'sh8000_0000;
    r.center_u = 32'sh7fff_ffff; r.center_v = 32'sh8000_0000;
    r.center_depth = 31'h7fff_ffff; r.joint_weight = 32'sh8000_0000;
    push_joint(r);
    r = '0;
    r.pred_x = 32'sh0001_0000; r.label_x = -32'sh0001_0000; r.center_depth = 31'd0;
    push_joint(r);
    r.pred_x = 32'sh0; r.label_x = 32'sh0;
    r.last_joint = 1'b1;
    push_joint(r);
    // A batch of one joint that closes straight away.
    push_joint(random_joint(1'b1));
    drain();

    // Weighting on, with the weight exactly one, just inside on either side, just outside and far off.
    write_all(32'sh0002_0000, 32'sh0003_0000, 32'sh0000_8000, -32'sh0000_8000,
              32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 1'b1);
    r = random_joint(1'b0); r.joint_weight = 32'sh0001_0000; push_joint(r);
    r = random_joint(1'b0); r.joint_weight = 32'sh0001_0041; push_joint(r);
    r = random_joint(1'b0); r.joint_weight = 32'sh0000_ffbf; push_joint(r);
    r = random_joint(1'b1); r.joint_weight = 32'sh0001_0042; push_joint(r);
    // Empty batch: nothing counts before the closing joint.
    r = random_joint(1'b0); r.joint_weight = 32'sh0; push_joint(r);
    r = random_joint(1'b1); r.joint_weight = 32'sh7fff_ffff; push_joint(r);
    drain();

    // Zero and negative focal lengths, extreme principal points and cube sizes; the
    // accumulator is driven towards its ceiling by huge distances.
    write_all(32'sh0, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    for (int i = 0; i < 6; i++) push_joint(random_joint(i == 5));
    r = '0; r.center_depth = 31'd0; r.pred_x = 32'sh7fff_ffff; r.last_joint = 1'b1;
    push_joint(r);
    drain();

    // Random phases across several settings, mostly well-formed batches.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_all(32'sh0001_0000, 32'sh0001_0000, 32'sh0, 32'sh0,
                     32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        1: write_all(-32'sh0004_0000, 32'sh0008_0000, $urandom, $urandom,
                     $urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0010_0000),
                     $urandom_range(0, 32'h0010_0000), 1'b1);
        2: write_all(32'sh7fff_ffff, -32'sh7fff_ffff, 32'sh0, 32'sh7fff_ffff,
                     32'h0, 32'h7fff_ffff, 32'h0, 1'b0);
        default: write_all($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      endcase
      phase_items = NumRandom / 6;
      while (phase_items > 0) begin
        automatic int n = $urandom_range(1, 12);
        if (n > phase_items) n = phase_items;
        if ($urandom_range(0, 9) == 0) begin
          // Noise: a run of joints that may or may not close a batch.
          for (int j = 0; j < n; j++) push_joint(random_joint($urandom_range(0, 3) == 0));
        end else begin
          queue_batch(n);
        end
        phase_items -= n;
      end
      if (phase == 2) begin
        // Hold the receiver off long enough for the block to fill and stall its input.
        hold_request = 1'b1;
      end
      if (phase == 5) quiet_tail = 1'b1;
      drain();
    end

    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    $display("Ran %0d joints and checked %0d results, %0d batches closed (%0d empty).",
             joints_sent, results_seen, batches_closed, empty_batches);
    $display("Settings covered reset, weighting, zero and negative focal lengths and extremes.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", mismatches,
               expected_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
